### hdl/sse_pkg.sv
package sse_pkg;

   // Table geometry and field widths.
   localparam int MAX_SERVERS = 16;
   localparam int RESP_BITS   = 20;
   localparam int IDX_BITS    = 4;
   localparam int CNT_BITS    = 5;
   localparam int KEY_BITS    = 32;
   localparam int SUM_BITS    = 24;

   // Reciprocal of ten, scaled by two to the 27th, rounded up.
   localparam int RECIP_SHIFT = 27;
   localparam logic [SUM_BITS-1:0] RECIP_TEN = 24'd13421773;

   // Opcodes.
   localparam logic [1:0] OP_SELECT = 2'd0;
   localparam logic [1:0] OP_LOAD   = 2'd1;
   localparam logic [1:0] OP_RESP   = 2'd2;
   localparam logic [1:0] OP_PROBE  = 2'd3;

   // Selection algorithms.
   localparam logic [2:0] ALG_RR   = 3'd0;
   localparam logic [2:0] ALG_WRR  = 3'd1;
   localparam logic [2:0] ALG_LC   = 3'd2;
   localparam logic [2:0] ALG_WLC  = 3'd3;
   localparam logic [2:0] ALG_LRT  = 3'd4;
   localparam logic [2:0] ALG_RES  = 3'd5;
   localparam logic [2:0] ALG_HASH = 3'd6;

   // Error codes.
   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_RANGE     = 2'd1;
   localparam logic [1:0] ERR_NO_SERVER = 2'd2;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 5;
   localparam logic [1:0] CSR_ALGORITHM  = 2'd0;
   localparam logic [1:0] CSR_ACTIVE     = 2'd1;
   localparam logic [1:0] CSR_FAIL_LIMIT = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_AVG_SUM, S_AVG_WRITE, S_RR, S_TOP, S_WRR,
      S_MIN, S_MIN_DONE, S_MOD, S_HASH_INIT, S_HASH, S_OUT
   } state_type;

   typedef enum logic [3:0] {
      ACT_NONE, ACT_CAPTURE, ACT_APPLY, ACT_AVG_SUM, ACT_AVG_WRITE,
      ACT_RR_STEP, ACT_TOP_STEP, ACT_WRR_STEP, ACT_MIN_STEP,
      ACT_MOD_STEP, ACT_HASH_INIT, ACT_HASH_STEP
   } action_type;

   typedef enum logic [1:0] {
      RES_ECHO, RES_CAND, RES_BEST, RES_ZERO
   } res_src_type;

   typedef struct packed {
      action_type  action;
      logic        res_load;
      res_src_type res_src;
      logic [1:0]  res_err;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] alg;
      logic       idx_bad;
      logic       scan_last;
      logic       mod_last;
      logic       cand_up;
      logic       wrr_ok;
      logic       any_now;
      logic       have;
   } status_type;

   // Remainder of a small value by the active count, one bit per step.
   function automatic logic [IDX_BITS-1:0] mod_small(input logic [CNT_BITS-1:0] x,
                                                     input logic [CNT_BITS-1:0] n);
      logic [CNT_BITS:0] r;
      r = '0;
      for (int b = CNT_BITS - 1; b >= 0; b--) begin
         r = {r[CNT_BITS-1:0], x[b]};
         if (r >= {1'b0, n}) begin
            r = r - {1'b0, n};
         end
      end
      return r[IDX_BITS-1:0];
   endfunction

endpackage

### hdl/sse_datapath.sv
module sse_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sse_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sse_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   input  logic [1:0]                          req_opcode,
   input  logic [3:0]                          req_server_index,
   input  logic [31:0]                         req_key_hash,
   input  logic [7:0]                          req_weight_value,
   input  logic [15:0]                         req_conn_value,
   input  logic [6:0]                          req_cpu_value,
   input  logic [6:0]                          req_mem_value,
   input  logic [19:0]                         req_response_sample,
   input  logic                                req_probe_ok,
   input  sse_pkg::cmd_type                    cmd,
   output sse_pkg::status_type                 status,
   output logic [3:0]                          rsp_chosen_server,
   output logic [1:0]                          rsp_error_code
);
   import sse_pkg::*;

   // Configuration registers.
   logic [2:0] algorithm_ff;
   logic [4:0] active_ff;
   logic [3:0] fail_limit_ff;

   // Captured item.
   logic [1:0]           op_ff;
   logic [IDX_BITS-1:0]  idx_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [7:0]           weight_v_ff;
   logic [15:0]          conn_v_ff;
   logic [6:0]           cpu_v_ff;
   logic [6:0]           mem_v_ff;
   logic [RESP_BITS-1:0] sample_ff;
   logic                 probe_ff;

   // Server table.
   logic [7:0]           weight_ff [MAX_SERVERS];
   logic [15:0]          conns_ff  [MAX_SERVERS];
   logic [6:0]           cpu_ff    [MAX_SERVERS];
   logic [6:0]           mem_ff    [MAX_SERVERS];
   logic [RESP_BITS-1:0] resp_ff   [MAX_SERVERS];
   logic                 up_ff     [MAX_SERVERS];
   logic [3:0]           fails_ff  [MAX_SERVERS];

   // Scan state.
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]  ptr_ff, ptr_in;
   logic [IDX_BITS-1:0]  mod_ff, mod_in;
   logic [IDX_BITS-1:0]  rr_pos_ff, rr_pos_in;
   logic [IDX_BITS-1:0]  wrr_pos_ff, wrr_pos_in;
   logic [7:0]           level_ff, level_in;
   logic [7:0]           top_ff, top_in;
   logic                 any_ff, any_in;
   logic                 have_ff, have_in;
   logic [IDX_BITS-1:0]  best_ff, best_in;
   logic [15:0]          best_conns_ff, best_conns_in;
   logic [7:0]           best_weight_ff, best_weight_in;
   logic [RESP_BITS-1:0] best_resp_ff, best_resp_in;
   logic [7:0]           best_load_ff, best_load_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [IDX_BITS-1:0]  res_idx_ff, res_idx_in;
   logic [1:0]           res_err_ff, res_err_in;
   logic [IDX_BITS-1:0]  out_idx_ff, out_idx_in;
   logic [1:0]           out_err_ff, out_err_in;

   logic [CNT_BITS-1:0]  n;
   logic [IDX_BITS-1:0]  rr_next, wrr_next, hash_next, rd_idx;
   logic [7:0]           level_new;
   logic [7:0]           e_weight;
   logic [15:0]          e_conns;
   logic [6:0]           e_cpu, e_mem;
   logic [RESP_BITS-1:0] e_resp;
   logic                 e_up;
   logic [3:0]           e_fails, fails_new;
   logic [7:0]           e_load;
   logic                 better;
   logic [SUM_BITS-1:0]  wlc_lhs, wlc_rhs;
   logic [CNT_BITS-1:0]  rem2;
   logic [2*SUM_BITS-1:0] quot_wide;
   logic                 entry_we;
   logic [7:0]           w_weight;
   logic [15:0]          w_conns;
   logic [6:0]           w_cpu, w_mem;
   logic [RESP_BITS-1:0] w_resp;
   logic                 w_up;
   logic [3:0]           w_fails;

   // Effective active count, clamped to the table.
   always_comb begin
      if (active_ff == '0) begin
         n = CNT_BITS'(1);
      end else if (active_ff > CNT_BITS'(MAX_SERVERS)) begin
         n = CNT_BITS'(MAX_SERVERS);
      end else begin
         n = active_ff;
      end
   end

   // Next positions of the rotating pointers.
   assign rr_next   = mod_small(CNT_BITS'(rr_pos_ff) + CNT_BITS'(1), n);
   assign wrr_next  = mod_small(CNT_BITS'(wrr_pos_ff) + CNT_BITS'(1), n);
   assign hash_next = (CNT_BITS'(ptr_ff) + CNT_BITS'(1) == n) ? '0 : ptr_ff + 1'b1;

   // Level after stepping weighted round robin.
   always_comb begin
      if (wrr_next == '0) begin
         level_new = (level_ff <= 8'd1) ? top_ff : level_ff - 8'd1;
      end else begin
         level_new = level_ff;
      end
   end

   // Single table read address.
   always_comb begin
      case (cmd.action) inside
         ACT_RR_STEP:  rd_idx = rr_next;
         ACT_WRR_STEP: rd_idx = wrr_next;
         ACT_APPLY, ACT_AVG_SUM, ACT_AVG_WRITE: rd_idx = idx_ff;
         default:      rd_idx = ptr_ff;
      endcase
   end

   assign e_weight = weight_ff[rd_idx];
   assign e_conns  = conns_ff[rd_idx];
   assign e_cpu    = cpu_ff[rd_idx];
   assign e_mem    = mem_ff[rd_idx];
   assign e_resp   = resp_ff[rd_idx];
   assign e_up     = up_ff[rd_idx];
   assign e_fails  = fails_ff[rd_idx];
   assign e_load   = 8'(e_cpu) + 8'(e_mem);

   // Comparison against the current best entry.
   assign wlc_lhs = SUM_BITS'(e_conns) * SUM_BITS'(best_weight_ff);
   assign wlc_rhs = SUM_BITS'(best_conns_ff) * SUM_BITS'(e_weight);
   always_comb begin
      case (algorithm_ff)
         ALG_WLC: better = wlc_lhs < wlc_rhs;
         ALG_LRT: better = e_resp < best_resp_ff;
         ALG_RES: better = e_load < best_load_ff;
         default: better = e_conns < best_conns_ff;
      endcase
   end

   // Key remainder step, most significant bit first.
   always_comb begin
      rem2 = {mod_ff, key_ff[5'd31 - cnt_ff]};
      if (rem2 >= n) begin
         rem2 = rem2 - n;
      end
   end

   // Response average divided by ten through the reciprocal.
   assign quot_wide = (2*SUM_BITS)'(sum_ff) * (2*SUM_BITS)'(RECIP_TEN);
   assign fails_new = (e_fails < 4'd15) ? e_fails + 4'd1 : e_fails;

   // Entry write values.
   always_comb begin
      entry_we = 1'b0;
      w_weight = e_weight;
      w_conns  = e_conns;
      w_cpu    = e_cpu;
      w_mem    = e_mem;
      w_resp   = e_resp;
      w_up     = e_up;
      w_fails  = e_fails;
      case (cmd.action)
         ACT_APPLY: begin
            entry_we = 1'b1;
            if (op_ff == OP_LOAD) begin
               w_weight = weight_v_ff;
               w_conns  = conn_v_ff;
               w_cpu    = (cpu_v_ff > 7'd100) ? 7'd100 : cpu_v_ff;
               w_mem    = (mem_v_ff > 7'd100) ? 7'd100 : mem_v_ff;
            end else if (probe_ff) begin
               w_fails = '0;
               w_up    = 1'b1;
            end else begin
               w_fails = fails_new;
               if (fails_new >= fail_limit_ff) begin
                  w_up = 1'b0;
               end
            end
         end
         ACT_AVG_WRITE: begin
            entry_we = 1'b1;
            w_resp   = quot_wide[RECIP_SHIFT +: RESP_BITS];
         end
         default: ;
      endcase
   end

   // Next values of the scan registers.
   always_comb begin
      cnt_in         = cnt_ff;
      ptr_in         = ptr_ff;
      mod_in         = mod_ff;
      rr_pos_in      = rr_pos_ff;
      wrr_pos_in     = wrr_pos_ff;
      level_in       = level_ff;
      top_in         = top_ff;
      any_in         = any_ff;
      have_in        = have_ff;
      best_in        = best_ff;
      best_conns_in  = best_conns_ff;
      best_weight_in = best_weight_ff;
      best_resp_in   = best_resp_ff;
      best_load_in   = best_load_ff;
      sum_in         = sum_ff;
      case (cmd.action)
         ACT_CAPTURE: begin
            cnt_in  = '0;
            ptr_in  = '0;
            mod_in  = '0;
            top_in  = '0;
            any_in  = 1'b0;
            have_in = 1'b0;
         end
         ACT_AVG_SUM: begin
            sum_in = SUM_BITS'(sample_ff) * SUM_BITS'(3) + SUM_BITS'(e_resp) * SUM_BITS'(7);
         end
         ACT_RR_STEP: begin
            rr_pos_in = rr_next;
            cnt_in    = cnt_ff + 1'b1;
         end
         ACT_TOP_STEP: begin
            if (e_up) begin
               any_in = 1'b1;
               if (e_weight > top_ff) begin
                  top_in = e_weight;
               end
            end
            ptr_in = ptr_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
         ACT_WRR_STEP: begin
            wrr_pos_in = wrr_next;
            level_in   = level_new;
         end
         ACT_MIN_STEP: begin
            if (e_up && (!have_ff || better)) begin
               have_in        = 1'b1;
               best_in        = ptr_ff;
               best_conns_in  = e_conns;
               best_weight_in = e_weight;
               best_resp_in   = e_resp;
               best_load_in   = e_load;
            end
            ptr_in = ptr_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
         ACT_MOD_STEP: begin
            mod_in = rem2[IDX_BITS-1:0];
            cnt_in = cnt_ff + 1'b1;
         end
         ACT_HASH_INIT: begin
            ptr_in = mod_ff;
            cnt_in = '0;
         end
         ACT_HASH_STEP: begin
            ptr_in = hash_next;
            cnt_in = cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // Result holding and output register.
   always_comb begin
      res_idx_in = res_idx_ff;
      res_err_in = res_err_ff;
      if (cmd.res_load) begin
         res_err_in = cmd.res_err;
         case (cmd.res_src)
            RES_ECHO: res_idx_in = idx_ff;
            RES_CAND: res_idx_in = rd_idx;
            RES_BEST: res_idx_in = best_ff;
            default:  res_idx_in = '0;
         endcase
      end
      out_idx_in = cmd.rsp_load ? res_idx_ff : out_idx_ff;
      out_err_in = cmd.rsp_load ? res_err_ff : out_err_ff;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         algorithm_ff  <= ALG_RR;
         active_ff     <= 5'd16;
         fail_limit_ff <= 4'd3;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ALGORITHM:  algorithm_ff  <= csr_write_data[2:0];
            CSR_ACTIVE:     active_ff     <= csr_write_data[4:0];
            CSR_FAIL_LIMIT: fail_limit_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // Server table with its reset contents.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SERVERS; i++) begin
            weight_ff[i] <= 8'd1;
            conns_ff[i]  <= '0;
            cpu_ff[i]    <= '0;
            mem_ff[i]    <= '0;
            resp_ff[i]   <= '0;
            up_ff[i]     <= 1'b1;
            fails_ff[i]  <= '0;
         end
      end else if (entry_we) begin
         weight_ff[rd_idx] <= w_weight;
         conns_ff[rd_idx]  <= w_conns;
         cpu_ff[rd_idx]    <= w_cpu;
         mem_ff[rd_idx]    <= w_mem;
         resp_ff[rd_idx]   <= w_resp;
         up_ff[rd_idx]     <= w_up;
         fails_ff[rd_idx]  <= w_fails;
      end
   end

   // Persistent selection state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rr_pos_ff  <= '0;
         wrr_pos_ff <= '0;
         level_ff   <= '0;
      end else begin
         rr_pos_ff  <= rr_pos_in;
         wrr_pos_ff <= wrr_pos_in;
         level_ff   <= level_in;
      end
   end

   // Working registers and captured item.
   always_ff @(posedge clock) begin
      if (cmd.action == ACT_CAPTURE) begin
         op_ff       <= req_opcode;
         idx_ff      <= req_server_index;
         key_ff      <= req_key_hash;
         weight_v_ff <= req_weight_value;
         conn_v_ff   <= req_conn_value;
         cpu_v_ff    <= req_cpu_value;
         mem_v_ff    <= req_mem_value;
         sample_ff   <= req_response_sample;
         probe_ff    <= req_probe_ok;
      end
      cnt_ff         <= cnt_in;
      ptr_ff         <= ptr_in;
      mod_ff         <= mod_in;
      top_ff         <= top_in;
      any_ff         <= any_in;
      have_ff        <= have_in;
      best_ff        <= best_in;
      best_conns_ff  <= best_conns_in;
      best_weight_ff <= best_weight_in;
      best_resp_ff   <= best_resp_in;
      best_load_ff   <= best_load_in;
      sum_ff         <= sum_in;
      res_idx_ff     <= res_idx_in;
      res_err_ff     <= res_err_in;
      out_idx_ff     <= out_idx_in;
      out_err_ff     <= out_err_in;
   end

   // Status toward the controller.
   always_comb begin
      status.op        = op_ff;
      status.alg       = algorithm_ff;
      status.idx_bad   = CNT_BITS'(idx_ff) >= n;
      status.scan_last = cnt_ff == n - CNT_BITS'(1);
      status.mod_last  = cnt_ff == CNT_BITS'(KEY_BITS - 1);
      status.cand_up   = e_up;
      status.wrr_ok    = e_weight >= level_new;
      status.any_now   = any_ff | e_up;
      status.have      = have_ff;
   end

   assign rsp_chosen_server = out_idx_ff;
   assign rsp_error_code    = out_err_ff;

endmodule

### hdl/sse_controller.sv
module sse_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  sse_pkg::status_type  status,
   output sse_pkg::cmd_type     cmd
);
   import sse_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (status.op != OP_SELECT) begin
               if (status.idx_bad || status.op != OP_RESP) state_in = S_OUT;
               else state_in = S_AVG_SUM;
            end else begin
               unique case (status.alg) inside
                  ALG_WRR: state_in = S_TOP;
                  ALG_LC, ALG_WLC, ALG_LRT, ALG_RES: state_in = S_MIN;
                  ALG_HASH: state_in = S_MOD;
                  default: state_in = S_RR;
               endcase
            end
         end
         S_AVG_SUM:   state_in = S_AVG_WRITE;
         S_AVG_WRITE: state_in = S_OUT;
         S_RR: begin
            if (status.cand_up || status.scan_last) state_in = S_OUT;
         end
         S_TOP: begin
            if (status.scan_last) state_in = status.any_now ? S_WRR : S_OUT;
         end
         S_WRR: begin
            if (status.cand_up && status.wrr_ok) state_in = S_OUT;
         end
         S_MIN: begin
            if (status.scan_last) state_in = S_MIN_DONE;
         end
         S_MIN_DONE: state_in = S_OUT;
         S_MOD: begin
            if (status.mod_last) state_in = S_HASH_INIT;
         end
         S_HASH_INIT: state_in = S_HASH;
         S_HASH: begin
            if (status.cand_up || status.scan_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.action   = ACT_NONE;
      cmd.res_load = 1'b0;
      cmd.res_src  = RES_ECHO;
      cmd.res_err  = ERR_OK;
      cmd.rsp_load = 1'b0;
      unique case (state_ff) inside
         S_IDLE: begin
            if (accept) cmd.action = ACT_CAPTURE;
         end
         S_DISPATCH: begin
            if (status.op != OP_SELECT) begin
               cmd.res_load = 1'b1;
               if (status.idx_bad) begin
                  cmd.res_err = ERR_RANGE;
               end else if (status.op != OP_RESP) begin
                  cmd.action = ACT_APPLY;
               end
            end
         end
         S_AVG_SUM: cmd.action = ACT_AVG_SUM;
         S_AVG_WRITE: begin
            cmd.action   = ACT_AVG_WRITE;
            cmd.res_load = 1'b1;
         end
         S_RR, S_HASH: begin
            cmd.action = (state_ff == S_RR) ? ACT_RR_STEP : ACT_HASH_STEP;
            if (status.cand_up) begin
               cmd.res_load = 1'b1;
               cmd.res_src  = RES_CAND;
            end else if (status.scan_last) begin
               cmd.res_load = 1'b1;
               cmd.res_src  = RES_ZERO;
               cmd.res_err  = ERR_NO_SERVER;
            end
         end
         S_TOP: begin
            cmd.action = ACT_TOP_STEP;
            if (status.scan_last && !status.any_now) begin
               cmd.res_load = 1'b1;
               cmd.res_src  = RES_ZERO;
               cmd.res_err  = ERR_NO_SERVER;
            end
         end
         S_WRR: begin
            cmd.action = ACT_WRR_STEP;
            if (status.cand_up && status.wrr_ok) begin
               cmd.res_load = 1'b1;
               cmd.res_src  = RES_CAND;
            end
         end
         S_MIN: cmd.action = ACT_MIN_STEP;
         S_MIN_DONE: begin
            cmd.res_load = 1'b1;
            cmd.res_src  = status.have ? RES_BEST : RES_ZERO;
            cmd.res_err  = status.have ? ERR_OK : ERR_NO_SERVER;
         end
         S_MOD: cmd.action = ACT_MOD_STEP;
         S_HASH_INIT: cmd.action = ACT_HASH_INIT;
         S_OUT: cmd.rsp_load = out_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A result only leaves from the output state into a free register.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (state_ff == S_OUT && out_free))
      else $error("result loaded while output register busy");

   // An accepted item is dispatched next cycle.
   a_dispatch: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DISPATCH)
      else $error("accepted item not dispatched");

   // A waiting result holds the controller in the output state.
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && rsp_stall) |=> state_ff == S_OUT)
      else $error("output state left while result blocked");

   // Loading a result always finishes the item.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("result load did not finish the item");

endmodule

### hdl/server_selection_engine.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   opcode, index, key hash, load, sample, probe
// rsp      out        rsp_valid/rsp_stall   chosen server, error code
// csr      in         csr_write_enable      csr_index, csr_write_data
//
// One item at a time: accept, a dispatch state, the work, an output state.
// Table updates pass from dispatch to output, samples through the averaging states;
// round robin probes entries until one is up, the minimum searches scan n entries,
// hash selection takes 32 one-bit remainder steps and then probes; weighted round
// robin adds a table scan and then steps one entry a cycle, all on one read port.
// Reset is synchronous and restores the table, settings and rotating pointers.
// A stalled result stays in the output register; a later item waits for it in S_OUT.
module server_selection_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sse_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sse_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_opcode,
   input  logic [3:0]                          req_server_index,
   input  logic [31:0]                         req_key_hash,
   input  logic [7:0]                          req_weight_value,
   input  logic [15:0]                         req_conn_value,
   input  logic [6:0]                          req_cpu_value,
   input  logic [6:0]                          req_mem_value,
   input  logic [19:0]                         req_response_sample,
   input  logic                                req_probe_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [3:0]                          rsp_chosen_server,
   output logic [1:0]                          rsp_error_code
);
   import sse_pkg::*;

   cmd_type    cmd;
   status_type status;

   sse_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sse_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_opcode          (req_opcode),
      .req_server_index    (req_server_index),
      .req_key_hash        (req_key_hash),
      .req_weight_value    (req_weight_value),
      .req_conn_value      (req_conn_value),
      .req_cpu_value       (req_cpu_value),
      .req_mem_value       (req_mem_value),
      .req_response_sample (req_response_sample),
      .req_probe_ok        (req_probe_ok),
      .cmd                 (cmd),
      .status              (status),
      .rsp_chosen_server   (rsp_chosen_server),
      .rsp_error_code      (rsp_error_code)
   );

endmodule
